>>> hw/rtl/checksummed_hex_line_framer_assert.svh
// assertion macros shared by the checker
`ifndef CHECKSUMMED_HEX_LINE_FRAMER_ASSERT_SVH
`define CHECKSUMMED_HEX_LINE_FRAMER_ASSERT_SVH

// same-cycle implication, off while reset is high
`define CHLF_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("chlf check failed");

// next-cycle implication, also checked around reset
`define CHLF_ASSERT_NXT(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("chlf check failed");

`endif

>>> hw/rtl/chlf_pkg.sv
package chlf_pkg;

   localparam int LINE_WIDTH_W = 6;
   localparam logic [LINE_WIDTH_W-1:0] LINE_WIDTH_MAX   = 6'd48;
   localparam logic [LINE_WIDTH_W-1:0] LINE_WIDTH_RESET = 6'd32;

   localparam int CMD_DEPTH_DEFAULT = 4;
   localparam int RSP_DEPTH_DEFAULT = 4;

   localparam logic [1:0] MODE_CHAR   = 2'd0;
   localparam logic [1:0] MODE_NIBBLE = 2'd1;
   localparam logic [1:0] MODE_CLOSE  = 2'd2;

   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_NEWLINE = 8'h0a;

   typedef struct packed {
      logic       close;
      logic [7:0] ch;
   } cmd_type;

   typedef struct packed {
      logic [7:0] ch;
      logic       last;
   } rsp_type;

   function automatic logic [7:0] hex_char(input logic [3:0] nib);
      logic [7:0] r;
      if (nib < 4'd10) begin
         r = 8'h30 + {4'd0, nib};
      end else begin
         r = 8'h57 + {4'd0, nib};
      end
      return r;
   endfunction

   // add modulo 255, both operands known below 255 / 256
   function automatic logic [7:0] fletch_add(input logic [7:0] s, input logic [7:0] c);
      logic [8:0] t;
      t = {1'b0, s} + {1'b0, c};
      if (t >= 9'd255) begin
         t = t - 9'd255;
      end
      return t[7:0];
   endfunction

endpackage

>>> hw/rtl/checksummed_hex_line_framer.sv
// checksummed hex line framer
// input queue side: drive req_mode/req_symbol with push; an item is taken on a
//   clock edge with push high and full low. mode 0 is a literal character,
//   mode 1 a hex nibble (low bits of req_symbol), mode 2 closes the file,
//   mode 3 is taken and dropped
// result queue side: while empty is low, rsp_out_char/rsp_last show the oldest
//   character; pop high with empty low takes it. rsp_last marks the final
//   character that one item causes
// config: line width written through csr_line_width with valid; ready is always
//   high, write only while the block is idle
// path: an item is written into the command queue; the sequencer then pops it
//   and pushes its character into the result queue, from which it can be
//   popped
// throughput: one character per cycle while the result queue has room, set by
//   the sequencer that emits one character a cycle; a full line adds four checksum
//   chars and a newline, close takes a dispatch step plus its padding and checksum
// stall: when the result queue fills, the sequencer holds; once the command
//   queue is full as well, full rises and input waits
// reset: synchronous, clears both queues, the sums and the position, width 32
module checksummed_hex_line_framer
   import chlf_pkg::*;
#(
   parameter int CMD_DEPTH = CMD_DEPTH_DEFAULT,
   parameter int RSP_DEPTH = RSP_DEPTH_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   // input item channel
   input  logic                    push,
   output logic                    full,
   input  logic [1:0]              req_mode,
   input  logic [7:0]              req_symbol,
   // result item channel
   output logic                    empty,
   input  logic                    pop,
   output logic [7:0]              rsp_out_char,
   output logic                    rsp_last,
   // line width register
   input  logic                    valid,
   output logic                    ready,
   input  logic [LINE_WIDTH_W-1:0] csr_line_width
);

   // front to command queue
   logic    cmd_push;
   cmd_type cmd_wr;
   logic    cmd_full;

   // command queue to sequencer
   cmd_type cmd_rd;
   logic    cmd_empty;
   logic    cmd_pop;

   // sequencer to result queue
   logic    out_push;
   rsp_type out_item;
   logic    out_full;
   rsp_type rsp_head;

   assign full  = cmd_full;
   assign ready = 1'b1;    // register write always taken

   // classify items, nibbles become ascii here
   chlf_front u_front (
      .push     (push),
      .mode     (req_mode),
      .symbol   (req_symbol),
      .cmd_full (cmd_full),
      .cmd_push (cmd_push),
      .cmd      (cmd_wr)
   );

   // short queue that decouples intake from line framing
   chlf_fifo #(
      .WIDTH ($bits(cmd_type)),
      .DEPTH (CMD_DEPTH)
   ) u_cmd_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_wr),
      .full      (cmd_full),
      .pop       (cmd_pop),
      .pop_data  (cmd_rd),
      .empty     (cmd_empty)
   );

   // line sequencer: characters, padding, checksums, newlines
   chlf_back u_back (
      .clock     (clock),
      .reset     (reset),
      .csr_write (valid && ready),
      .csr_data  (csr_line_width),
      .cmd_valid (!cmd_empty),
      .cmd       (cmd_rd),
      .cmd_pop   (cmd_pop),
      .out_full  (out_full),
      .out_push  (out_push),
      .out_item  (out_item)
   );

   // result queue, parts the sequencer from the receiver
   chlf_fifo #(
      .WIDTH ($bits(rsp_type)),
      .DEPTH (RSP_DEPTH)
   ) u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (out_push),
      .push_data (out_item),
      .full      (out_full),
      .pop       (pop),
      .pop_data  (rsp_head),
      .empty     (empty)
   );

   assign rsp_out_char = rsp_head.ch;
   assign rsp_last     = rsp_head.last;

endmodule

>>> hw/rtl/chlf_fifo.sv
module chlf_fifo
   import chlf_pkg::*;
#(
   parameter int WIDTH = 9,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam logic [AW:0] DEPTH_CNT = (AW + 1)'(DEPTH);
   localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [AW:0]      count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == DEPTH_CNT);
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   // pointers wrap at the last entry, so any depth works
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> hw/rtl/chlf_front.sv
module chlf_front
   import chlf_pkg::*;
(
   input  logic       push,
   input  logic [1:0] mode,
   input  logic [7:0] symbol,
   input  logic       cmd_full,
   output logic       cmd_push,
   output cmd_type    cmd
);

   logic keep;

   // nibbles turn into lower-case hex here, unused mode is dropped
   always_comb begin
      keep      = 1'b1;
      cmd.close = 1'b0;
      cmd.ch    = symbol;
      case (mode)
         MODE_CHAR: begin
            cmd.ch = symbol;
         end
         MODE_NIBBLE: begin
            cmd.ch = hex_char(symbol[3:0]);
         end
         MODE_CLOSE: begin
            cmd.close = 1'b1;
            cmd.ch    = 8'd0;
         end
         default: begin
            keep = 1'b0;
         end
      endcase
   end

   assign cmd_push = push && !cmd_full && keep;

endmodule

>>> hw/rtl/chlf_back.sv
module chlf_back
   import chlf_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_write,
   input  logic [LINE_WIDTH_W-1:0] csr_data,
   input  logic                    cmd_valid,
   input  cmd_type                 cmd,
   output logic                    cmd_pop,
   input  logic                    out_full,
   output logic                    out_push,
   output rsp_type                 out_item
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_PUT   = 2'd1;
   localparam logic [1:0] ST_FLUSH = 2'd2;
   localparam logic [1:0] ST_PAD   = 2'd3;

   // where a flush goes once its newline is out
   localparam logic [1:0] RET_PUT    = 2'd0;
   localparam logic [1:0] RET_NEXT   = 2'd1;
   localparam logic [1:0] RET_DIGITS = 2'd2;
   localparam logic [1:0] RET_DONE   = 2'd3;

   localparam logic [2:0] FIDX_NEWLINE = 3'd4;
   localparam logic [1:0] VD_LAST      = 2'd3;

   logic [1:0]              state_ff, state_in;
   logic [1:0]              ret_ff, ret_in;
   logic [2:0]              fidx_ff, fidx_in;
   logic [1:0]              vd_ff, vd_in;
   logic                    close_ff, close_in;
   logic [7:0]              ch_ff, ch_in;
   logic [LINE_WIDTH_W-1:0] pos_ff, pos_in;
   logic [LINE_WIDTH_W-1:0] width_ff, width_in;
   logic [7:0]              ls1_ff, ls1_in, ls2_ff, ls2_in;
   logic [7:0]              vs1_ff, vs1_in, vs2_ff, vs2_in;
   logic [7:0]              va_ff, va_in, vb_ff, vb_in;

   logic [LINE_WIDTH_W-1:0] width_use;
   logic [LINE_WIDTH_W:0]   pos_inc;
   logic                    pos_full, inc_full, near_end, go;
   logic [7:0]              app_char, app_s1, app_s2;
   logic [7:0]              flush_char, fl_s1, fl_s2;

   function automatic logic [7:0] vert_digit(input logic [1:0] idx,
                                             input logic [7:0] a,
                                             input logic [7:0] b);
      logic [7:0] r;
      case (idx)
         2'd0:    r = hex_char(a[7:4]);
         2'd1:    r = hex_char(a[3:0]);
         2'd2:    r = hex_char(b[7:4]);
         default: r = hex_char(b[3:0]);
      endcase
      return r;
   endfunction

   always_comb begin
      if (width_ff == '0) begin
         width_use = LINE_WIDTH_W'(1);
      end else if (width_ff > LINE_WIDTH_MAX) begin
         width_use = LINE_WIDTH_MAX;
      end else begin
         width_use = width_ff;
      end
   end

   assign pos_inc  = {1'b0, pos_ff} + 1'b1;
   assign pos_full = (pos_ff >= width_use);
   assign inc_full = (pos_inc >= {1'b0, width_use});
   assign near_end = (({1'b0, pos_ff} + (LINE_WIDTH_W + 1)'(4)) > {1'b0, width_use});
   assign go       = !out_full;

   // character appended to the line this cycle
   always_comb begin
      case (state_ff)
         ST_IDLE: app_char = cmd.ch;
         ST_PUT:  app_char = ch_ff;
         default: app_char = CHAR_ZERO;
      endcase
      app_s1 = fletch_add(ls1_ff, app_char);
      app_s2 = fletch_add(ls2_ff, app_s1);
   end

   always_comb begin
      case (fidx_ff)
         3'd0:    flush_char = hex_char(ls1_ff[7:4]);
         3'd1:    flush_char = hex_char(ls1_ff[3:0]);
         3'd2:    flush_char = hex_char(ls2_ff[7:4]);
         3'd3:    flush_char = hex_char(ls2_ff[3:0]);
         default: flush_char = CHAR_NEWLINE;
      endcase
      fl_s1 = fletch_add(vs1_ff, flush_char);
      fl_s2 = fletch_add(vs2_ff, fl_s1);
   end

   always_comb begin
      state_in = state_ff;
      ret_in   = ret_ff;
      fidx_in  = fidx_ff;
      vd_in    = vd_ff;
      close_in = close_ff;
      ch_in    = ch_ff;
      pos_in   = pos_ff;
      width_in = csr_write ? csr_data : width_ff;
      ls1_in   = ls1_ff;
      ls2_in   = ls2_ff;
      vs1_in   = vs1_ff;
      vs2_in   = vs2_ff;
      va_in    = va_ff;
      vb_in    = vb_ff;
      cmd_pop  = 1'b0;
      out_push = 1'b0;
      out_item = '0;

      case (state_ff)
         ST_IDLE: begin
            if (go && cmd_valid) begin
               cmd_pop = 1'b1;
               fidx_in = '0;
               if (!cmd.close) begin
                  close_in = 1'b0;
                  if (pos_full) begin
                     ch_in    = cmd.ch;
                     state_in = ST_FLUSH;
                     ret_in   = RET_PUT;
                  end else begin
                     out_push      = 1'b1;
                     out_item.ch   = cmd.ch;
                     out_item.last = !inc_full;
                     ls1_in        = app_s1;
                     ls2_in        = app_s2;
                     pos_in        = pos_inc[LINE_WIDTH_W-1:0];
                     if (inc_full) begin
                        state_in = ST_FLUSH;
                        ret_in   = RET_NEXT;
                     end
                  end
               end else begin
                  close_in = 1'b1;
                  if (pos_ff != '0 && (pos_full || near_end)) begin
                     ret_in   = RET_DIGITS;
                     state_in = pos_full ? ST_FLUSH : ST_PAD;
                  end else begin
                     va_in    = vs1_ff;
                     vb_in    = vs2_ff;
                     vd_in    = '0;
                     ch_in    = hex_char(vs1_ff[7:4]);
                     state_in = ST_PUT;
                  end
               end
            end
         end
         ST_PUT: begin
            if (go) begin
               fidx_in = '0;
               if (pos_full) begin
                  state_in = ST_FLUSH;
                  ret_in   = RET_PUT;
               end else begin
                  out_push      = 1'b1;
                  out_item.ch   = ch_ff;
                  out_item.last = !close_ff && !inc_full;
                  ls1_in        = app_s1;
                  ls2_in        = app_s2;
                  pos_in        = pos_inc[LINE_WIDTH_W-1:0];
                  if (inc_full) begin
                     state_in = ST_FLUSH;
                     ret_in   = RET_NEXT;
                  end else if (!close_ff) begin
                     state_in = ST_IDLE;
                  end else if (vd_ff != VD_LAST) begin
                     vd_in = vd_ff + 1'b1;
                     ch_in = vert_digit(vd_ff + 1'b1, va_ff, vb_ff);
                  end else begin
                     state_in = ST_PAD;
                     ret_in   = RET_DONE;
                  end
               end
            end
         end
         ST_PAD: begin
            if (go) begin
               out_push      = 1'b1;
               out_item.ch   = CHAR_ZERO;
               out_item.last = 1'b0;
               ls1_in        = app_s1;
               ls2_in        = app_s2;
               pos_in        = pos_inc[LINE_WIDTH_W-1:0];
               if (inc_full) begin
                  state_in = ST_FLUSH;
                  fidx_in  = '0;
               end
            end
         end
         ST_FLUSH: begin
            if (go) begin
               out_push    = 1'b1;
               out_item.ch = flush_char;
               if (fidx_ff != FIDX_NEWLINE) begin
                  vs1_in  = fl_s1;
                  vs2_in  = fl_s2;
                  fidx_in = fidx_ff + 1'b1;
               end else begin
                  out_item.last = (ret_ff == RET_DONE) ||
                                  (ret_ff == RET_NEXT && (!close_ff || vd_ff == VD_LAST));
                  ls1_in = '0;
                  ls2_in = '0;
                  pos_in = '0;
                  case (ret_ff)
                     RET_PUT: begin
                        state_in = ST_PUT;
                     end
                     RET_NEXT: begin
                        if (!close_ff) begin
                           state_in = ST_IDLE;
                        end else if (vd_ff != VD_LAST) begin
                           vd_in    = vd_ff + 1'b1;
                           ch_in    = vert_digit(vd_ff + 1'b1, va_ff, vb_ff);
                           state_in = ST_PUT;
                        end else begin
                           vs1_in   = '0;
                           vs2_in   = '0;
                           state_in = ST_IDLE;
                        end
                     end
                     RET_DIGITS: begin
                        va_in    = vs1_ff;
                        vb_in    = vs2_ff;
                        vd_in    = '0;
                        ch_in    = hex_char(vs1_ff[7:4]);
                        state_in = ST_PUT;
                     end
                     default: begin
                        vs1_in   = '0;
                        vs2_in   = '0;
                        state_in = ST_IDLE;
                     end
                  endcase
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ret_ff   <= RET_DONE;
         fidx_ff  <= '0;
         vd_ff    <= '0;
         close_ff <= 1'b0;
         pos_ff   <= '0;
         width_ff <= LINE_WIDTH_RESET;
         ls1_ff   <= '0;
         ls2_ff   <= '0;
         vs1_ff   <= '0;
         vs2_ff   <= '0;
      end else begin
         state_ff <= state_in;
         ret_ff   <= ret_in;
         fidx_ff  <= fidx_in;
         vd_ff    <= vd_in;
         close_ff <= close_in;
         pos_ff   <= pos_in;
         width_ff <= width_in;
         ls1_ff   <= ls1_in;
         ls2_ff   <= ls2_in;
         vs1_ff   <= vs1_in;
         vs2_ff   <= vs2_in;
      end
   end

   always_ff @(posedge clock) begin
      ch_ff <= ch_in;
      va_ff <= va_in;
      vb_ff <= vb_in;
   end

endmodule

>>> hw/rtl/chlf_checker.sv
`include "checksummed_hex_line_framer_assert.svh"

module chlf_checker
   import chlf_pkg::*;
(
   input logic                    clock,
   input logic                    reset,
   input logic                    push,
   input logic                    full,
   input logic [1:0]              req_mode,
   input logic [7:0]              req_symbol,
   input logic                    empty,
   input logic                    pop,
   input logic [7:0]              rsp_out_char,
   input logic                    rsp_last,
   input logic                    valid,
   input logic                    ready,
   input logic [LINE_WIDTH_W-1:0] csr_line_width
);

   // a waiting character is not lost or changed while the receiver stalls
   `CHLF_ASSERT_NXT(a_rsp_hold, clock, !reset && !empty && !pop, !empty && $stable(rsp_out_char) && $stable(rsp_last))

   // both queues come out of reset drained
   `CHLF_ASSERT_NXT(a_reset_clear, clock, reset, empty && !full)

   // the line width register never pushes back
   `CHLF_ASSERT_IMP(a_csr_ready, clock, reset, valid, ready)

endmodule

bind checksummed_hex_line_framer chlf_checker u_chlf_checker (.*);
